// ===== sv/tmto_pkg.sv =====
// Package for the trimmed-mean timestamp offset block.
// Holds the window size, derived widths, divider selects and the
// controller/datapath command and status structs. No dependencies.
package tmto_pkg;

    localparam int WINDOW     = 10;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int STAMP_W    = 32;
    localparam int OFS_W      = STAMP_W + 1;
    localparam int WIN_LOG    = $clog2(WINDOW);
    localparam int SUM_W      = STAMP_W + ((WIN_LOG < 4) ? 4 : WIN_LOG);
    localparam int TRIM_SHIFT = 3;
    localparam int NCH        = 3;
    localparam int DIV_CNT_W  = $clog2(STAMP_W);

    localparam logic [STAMP_W-1:0] UNIT_RESET = STAMP_W'(100000);

    localparam int CH_GPS = 0;
    localparam int CH_NR  = 1;
    localparam int CH_LTE = 2;

    localparam logic [1:0] DSEL_UNIT = 2'd0;
    localparam logic [1:0] DSEL_NR   = 2'd1;
    localparam logic [1:0] DSEL_LTE  = 2'd2;

    typedef struct packed {
        logic       store;
        logic       scan_clr;
        logic       scan_step;
        logic       mean_ld;
        logic       div_start;
        logic [1:0] div_sel;
        logic       unit_ld;
        logic       nr_ld;
        logic       lte_ld;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic scan_last;
        logic div_done;
        logic unit_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/tmto_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on tmto_pkg for widths.
module tmto_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_dividend,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [tmto_pkg::STAMP_W-1:0]  o_quotient
);

    logic                            r_busy;
    logic [tmto_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [tmto_pkg::STAMP_W-1:0]    r_rem;
    logic [tmto_pkg::STAMP_W-1:0]    r_quo;
    logic [tmto_pkg::STAMP_W-1:0]    r_dvs;
    logic [tmto_pkg::STAMP_W:0]      shifted;
    logic [tmto_pkg::STAMP_W:0]      trial;
    logic                            fits;

    assign shifted = {r_rem, r_quo[tmto_pkg::STAMP_W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tmto_pkg::DIV_CNT_W'(tmto_pkg::STAMP_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[tmto_pkg::STAMP_W-1:0] : shifted[tmto_pkg::STAMP_W-1:0];
            r_quo <= {r_quo[tmto_pkg::STAMP_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;

endmodule

// ===== sv/tmto_dp.sv =====
// Datapath: sample rings, min/max/sum scan, trimmed means, offsets and
// output register. Depends on tmto_pkg and tmto_div.
module tmto_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_cfg_wdata,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_gps_stamp,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_nr_stamp,
    input  logic [tmto_pkg::STAMP_W-1:0]  i_lte_stamp,
    input  tmto_pkg::t_cmd                i_cmd,
    output tmto_pkg::t_sts                o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [tmto_pkg::STAMP_W-1:0]  o_gps_mean,
    output logic [tmto_pkg::STAMP_W-1:0]  o_nr_mean,
    output logic [tmto_pkg::STAMP_W-1:0]  o_lte_mean,
    output logic signed [tmto_pkg::OFS_W-1:0] o_nr_offset,
    output logic signed [tmto_pkg::OFS_W-1:0] o_lte_offset,
    output logic                          o_zero_unit
);

    localparam int SW = tmto_pkg::STAMP_W;
    localparam int MW = tmto_pkg::SUM_W - tmto_pkg::TRIM_SHIFT;

    logic [SW-1:0]                 r_unit_div;
    logic [SW-1:0]                 r_ring [tmto_pkg::NCH][tmto_pkg::WINDOW];
    logic [tmto_pkg::SLOT_W-1:0]   r_slot;
    logic                          r_seen;
    logic [tmto_pkg::SLOT_W-1:0]   r_idx;
    logic [tmto_pkg::SUM_W-1:0]    r_sum [tmto_pkg::NCH];
    logic [SW-1:0]                 r_min [tmto_pkg::NCH];
    logic [SW-1:0]                 r_max [tmto_pkg::NCH];
    logic [SW-1:0]                 r_mean [tmto_pkg::NCH];
    logic [SW-1:0]                 r_unit;
    logic [SW-1:0]                 r_nr_q;
    logic [SW-1:0]                 r_lte_q;
    logic                          r_out_valid;

    logic [SW-1:0]                 in_stamp [tmto_pkg::NCH];
    logic [SW-1:0]                 rd [tmto_pkg::NCH];
    logic [tmto_pkg::SUM_W-1:0]    trimmed [tmto_pkg::NCH];
    logic [MW-1:0]                 shifted [tmto_pkg::NCH];
    logic [SW-1:0]                 n_mean [tmto_pkg::NCH];
    logic                          nr_neg;
    logic                          lte_neg;
    logic [SW-1:0]                 nr_mag;
    logic [SW-1:0]                 lte_mag;
    logic [SW-1:0]                 div_dvd;
    logic [SW-1:0]                 div_dvs;
    logic                          div_done;
    logic [SW-1:0]                 div_q;
    logic                          udiv_zero;
    logic                          out_free;
    logic [tmto_pkg::OFS_W-1:0]    nr_q_ext;
    logic [tmto_pkg::OFS_W-1:0]    lte_q_ext;

    assign in_stamp[tmto_pkg::CH_GPS] = i_gps_stamp;
    assign in_stamp[tmto_pkg::CH_NR]  = i_nr_stamp;
    assign in_stamp[tmto_pkg::CH_LTE] = i_lte_stamp;

    assign udiv_zero = (r_unit_div == '0);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_div <= tmto_pkg::UNIT_RESET;
        end else if (i_cfg_we) begin
            r_unit_div <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.store) begin
            r_seen <= 1'b1;
            r_slot <= (r_slot == tmto_pkg::SLOT_W'(tmto_pkg::WINDOW - 1)) ?
                      '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < tmto_pkg::NCH; c++) begin
            if (i_cmd.store) begin
                r_ring[c][r_slot] <= in_stamp[c];
            end
        end
    end

    // Scan one ring entry per cycle on all three lanes
    always_comb begin
        for (int c = 0; c < tmto_pkg::NCH; c++) begin
            rd[c]      = r_ring[c][r_idx];
            trimmed[c] = r_sum[c] - tmto_pkg::SUM_W'(r_min[c]) - tmto_pkg::SUM_W'(r_max[c]);
            shifted[c] = trimmed[c][tmto_pkg::SUM_W-1:tmto_pkg::TRIM_SHIFT];
            n_mean[c]  = (shifted[c][MW-1:SW] != '0) ? '1 : shifted[c][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
            for (int c = 0; c < tmto_pkg::NCH; c++) begin
                r_sum[c] <= '0;
                r_min[c] <= '1;
                r_max[c] <= '0;
            end
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            for (int c = 0; c < tmto_pkg::NCH; c++) begin
                r_sum[c] <= r_sum[c] + tmto_pkg::SUM_W'(rd[c]);
                if (rd[c] < r_min[c]) r_min[c] <= rd[c];
                if (rd[c] > r_max[c]) r_max[c] <= rd[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_ld) begin
            for (int c = 0; c < tmto_pkg::NCH; c++) begin
                r_mean[c] <= n_mean[c];
            end
        end
    end

    assign nr_neg  = r_mean[tmto_pkg::CH_NR]  > r_mean[tmto_pkg::CH_GPS];
    assign lte_neg = r_mean[tmto_pkg::CH_LTE] > r_mean[tmto_pkg::CH_GPS];
    assign nr_mag  = nr_neg ? r_mean[tmto_pkg::CH_NR] - r_mean[tmto_pkg::CH_GPS]
                            : r_mean[tmto_pkg::CH_GPS] - r_mean[tmto_pkg::CH_NR];
    assign lte_mag = lte_neg ? r_mean[tmto_pkg::CH_LTE] - r_mean[tmto_pkg::CH_GPS]
                             : r_mean[tmto_pkg::CH_GPS] - r_mean[tmto_pkg::CH_LTE];

    always_comb begin
        unique case (i_cmd.div_sel)
            tmto_pkg::DSEL_NR: begin
                div_dvd = nr_mag;
                div_dvs = r_unit;
            end
            tmto_pkg::DSEL_LTE: begin
                div_dvd = lte_mag;
                div_dvs = r_unit;
            end
            default: begin
                div_dvd = r_mean[tmto_pkg::CH_GPS];
                div_dvs = r_unit_div;
            end
        endcase
    end

    tmto_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.unit_ld) r_unit  <= udiv_zero ? '0 : div_q;
        if (i_cmd.nr_ld)   r_nr_q  <= div_q;
        if (i_cmd.lte_ld)  r_lte_q <= div_q;
    end

    assign nr_q_ext  = {1'b0, r_nr_q};
    assign lte_q_ext = {1'b0, r_lte_q};

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_gps_mean  <= r_mean[tmto_pkg::CH_GPS];
            o_nr_mean   <= r_mean[tmto_pkg::CH_NR];
            o_lte_mean  <= r_mean[tmto_pkg::CH_LTE];
            o_zero_unit <= (r_unit == '0);
            if (r_unit == '0) begin
                o_nr_offset  <= '0;
                o_lte_offset <= '0;
            end else begin
                o_nr_offset  <= nr_neg  ? -nr_q_ext  : nr_q_ext;
                o_lte_offset <= lte_neg ? -lte_q_ext : lte_q_ext;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.emit      = (r_slot == '0) && r_seen;
    assign o_sts.scan_last = (r_idx == tmto_pkg::SLOT_W'(tmto_pkg::WINDOW - 1));
    assign o_sts.div_done  = div_done;
    assign o_sts.unit_zero = (r_unit == '0);
    assign o_sts.out_free  = out_free;

endmodule

// ===== sv/tmto_ctrl.sv =====
// Controller state machine: sequences store, scan, means, divisions and
// output load. Depends on tmto_pkg.
module tmto_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_sample_valid,
    output logic            o_in_stall,
    input  tmto_pkg::t_sts  i_sts,
    output tmto_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_MEAN  = 4'd2;
    localparam logic [3:0] S_UNIT  = 4'd3;
    localparam logic [3:0] S_UWAIT = 4'd4;
    localparam logic [3:0] S_NR    = 4'd5;
    localparam logic [3:0] S_NWAIT = 4'd6;
    localparam logic [3:0] S_LTE   = 4'd7;
    localparam logic [3:0] S_LWAIT = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = tmto_pkg::DSEL_UNIT;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sample_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.emit) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean_ld = 1'b1;
                n_state = S_UNIT;
            end
            S_UNIT: begin
                o_cmd.div_start = 1'b1;
                n_state = S_UWAIT;
            end
            S_UWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.unit_ld = 1'b1;
                    n_state = S_NR;
                end
            end
            S_NR: begin
                o_cmd.div_sel = tmto_pkg::DSEL_NR;
                if (i_sts.unit_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_NWAIT;
                end
            end
            S_NWAIT: begin
                o_cmd.div_sel = tmto_pkg::DSEL_NR;
                if (i_sts.div_done) begin
                    o_cmd.nr_ld = 1'b1;
                    n_state = S_LTE;
                end
            end
            S_LTE: begin
                o_cmd.div_sel   = tmto_pkg::DSEL_LTE;
                o_cmd.div_start = 1'b1;
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                o_cmd.div_sel = tmto_pkg::DSEL_LTE;
                if (i_sts.div_done) begin
                    o_cmd.lte_ld = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/trimmed_mean_timestamp_offset.sv =====
// A transaction that completes a window scans the ten-entry ring, then runs three serial
// divisions (unit, NR, LTE; only the unit one for a zero scale unit) on the single shared
// divider; any other transaction does not stall the input. The input stalls until the result
// is loaded into the output register, which frees the input side. Reset (synchronous,
// active low) zeroes the slot and first-sample flag and loads unit_divisor with 100000;
// ring entries are all rewritten before the first result.
module trimmed_mean_timestamp_offset (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tmto_pkg::STAMP_W-1:0]           i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_sample_valid,
    input  logic [tmto_pkg::STAMP_W-1:0]           i_gps_stamp,
    input  logic [tmto_pkg::STAMP_W-1:0]           i_nr_stamp,
    input  logic [tmto_pkg::STAMP_W-1:0]           i_lte_stamp,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [tmto_pkg::STAMP_W-1:0]           o_gps_mean,
    output logic [tmto_pkg::STAMP_W-1:0]           o_nr_mean,
    output logic [tmto_pkg::STAMP_W-1:0]           o_lte_mean,
    output logic signed [tmto_pkg::OFS_W-1:0]      o_nr_offset,
    output logic signed [tmto_pkg::OFS_W-1:0]      o_lte_offset,
    output logic                                   o_zero_unit
);

    tmto_pkg::t_cmd cmd;
    tmto_pkg::t_sts sts;

    tmto_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_sample_valid (i_sample_valid),
        .o_in_stall     (o_in_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    tmto_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_gps_stamp  (i_gps_stamp),
        .i_nr_stamp   (i_nr_stamp),
        .i_lte_stamp  (i_lte_stamp),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_gps_mean   (o_gps_mean),
        .o_nr_mean    (o_nr_mean),
        .o_lte_mean   (o_lte_mean),
        .o_nr_offset  (o_nr_offset),
        .o_lte_offset (o_lte_offset),
        .o_zero_unit  (o_zero_unit)
    );

endmodule

// ===== dv/trimmed_mean_timestamp_offset_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trimmed_mean_timestamp_offset: timestamp samples in,
// ten-entry trimmed means and scaled NR/LTE offsets predicted and checked in order.
// Depends on tmto_pkg and the trimmed_mean_timestamp_offset RTL only.
module trimmed_mean_timestamp_offset_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTED  = 10;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_ITEMS    = 40;

    typedef struct packed {
        logic [tmto_pkg::STAMP_W-1:0] gps_mean;
        logic [tmto_pkg::STAMP_W-1:0] nr_mean;
        logic [tmto_pkg::STAMP_W-1:0] lte_mean;
        logic [tmto_pkg::OFS_W-1:0]   nr_offset;
        logic [tmto_pkg::OFS_W-1:0]   lte_offset;
        logic                         zero_unit;
    } t_offset_report;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [tmto_pkg::STAMP_W-1:0]        i_cfg_wdata;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_sample_valid;
    logic [tmto_pkg::STAMP_W-1:0]        i_gps_stamp;
    logic [tmto_pkg::STAMP_W-1:0]        i_nr_stamp;
    logic [tmto_pkg::STAMP_W-1:0]        i_lte_stamp;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [tmto_pkg::STAMP_W-1:0]        o_gps_mean;
    logic [tmto_pkg::STAMP_W-1:0]        o_nr_mean;
    logic [tmto_pkg::STAMP_W-1:0]        o_lte_mean;
    logic signed [tmto_pkg::OFS_W-1:0]   o_nr_offset;
    logic signed [tmto_pkg::OFS_W-1:0]   o_lte_offset;
    logic                                o_zero_unit;

    trimmed_mean_timestamp_offset dut (.*);

    logic [tmto_pkg::STAMP_W-1:0] stamp_ring [tmto_pkg::NCH][tmto_pkg::WINDOW];
    int                           next_slot;
    bit                           have_first;
    logic [tmto_pkg::STAMP_W-1:0] unit_div;
    t_offset_report               expected_reports[$];

    int mismatches      = 0;
    int samples_sent    = 0;
    int results_seen    = 0;
    int zero_unit_seen  = 0;
    int settings_used   = 0;
    int in_stalled      = 0;
    int cycles          = 0;
    bit tx_idle         = 1'b1;
    bit rx_idle         = 1'b1;
    bit hold_req        = 1'b0;
    logic [tmto_pkg::STAMP_W-1:0] track_base = '0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [tmto_pkg::STAMP_W-1:0] trimmed_mean_of(input int ch);
        logic [63:0] total, lo, hi;
        total = '0;
        lo    = 64'hFFFF_FFFF;
        hi    = '0;
        for (int k = 0; k < tmto_pkg::WINDOW; k++) begin
            total += stamp_ring[ch][k];
            if (stamp_ring[ch][k] > hi) hi = stamp_ring[ch][k];
            if (stamp_ring[ch][k] < lo) lo = stamp_ring[ch][k];
        end
        total = (total - lo - hi) >> tmto_pkg::TRIM_SHIFT;
        return (total > 64'hFFFF_FFFF) ? '1 : total[tmto_pkg::STAMP_W-1:0];
    endfunction

    function automatic logic [tmto_pkg::OFS_W-1:0] scaled_gap(
        input logic [63:0] base_mean,
        input logic [63:0] other_mean,
        input logic [63:0] scale
    );
        logic [63:0] q;
        if (base_mean >= other_mean) q = (base_mean - other_mean) / scale;
        else q = 64'd0 - (other_mean - base_mean) / scale;
        return q[tmto_pkg::OFS_W-1:0];
    endfunction

    function automatic void predict_sample(input logic [tmto_pkg::STAMP_W-1:0] g, n, l);
        t_offset_report rep;
        logic [63:0]    scale;
        int             slot;
        slot = next_slot;
        stamp_ring[tmto_pkg::CH_GPS][slot] = g;
        stamp_ring[tmto_pkg::CH_NR][slot]  = n;
        stamp_ring[tmto_pkg::CH_LTE][slot] = l;
        next_slot = (slot + 1 >= tmto_pkg::WINDOW) ? 0 : slot + 1;
        if (slot != 0 || !have_first) begin
            have_first = 1'b1;
            return;
        end
        rep.gps_mean  = trimmed_mean_of(tmto_pkg::CH_GPS);
        rep.nr_mean   = trimmed_mean_of(tmto_pkg::CH_NR);
        rep.lte_mean  = trimmed_mean_of(tmto_pkg::CH_LTE);
        scale         = (unit_div == '0) ? 64'd0 : 64'(rep.gps_mean) / 64'(unit_div);
        rep.zero_unit = (scale == 64'd0);
        rep.nr_offset  = rep.zero_unit ? '0 : scaled_gap(rep.gps_mean, rep.nr_mean, scale);
        rep.lte_offset = rep.zero_unit ? '0 : scaled_gap(rep.gps_mean, rep.lte_mean, scale);
        expected_reports.push_back(rep);
    endfunction

    function automatic void flag_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("Mismatch on %s in result %0d: expected %h, got %h",
                         name, results_seen, want, got);
        end
    endfunction

    function automatic logic [tmto_pkg::STAMP_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [tmto_pkg::STAMP_W-1:0] drift();
        logic [tmto_pkg::STAMP_W-1:0] mag;
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    task automatic pick_stamps(output logic [tmto_pkg::STAMP_W-1:0] g, n, l);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            track_base += $urandom_range(100, 200000);
            g = track_base + $urandom_range(0, 255);
            n = g + drift();
            l = g + drift();
        end else if (r < 85) begin
            g = $urandom;
            n = $urandom;
            l = $urandom;
        end else begin
            g = corner_value();
            n = corner_value();
            l = corner_value();
        end
    endtask

    task automatic send_sample(input bit sv, input logic [tmto_pkg::STAMP_W-1:0] g, n, l);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_valid <= sv;
        i_gps_stamp    <= g;
        i_nr_stamp     <= n;
        i_lte_stamp    <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (sv) predict_sample(g, n, l);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_unit_divisor(input logic [tmto_pkg::STAMP_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        unit_div = value;
        settings_used++;
    endtask

    // First sample, ignored items, full-scale window, then a window with a zero scale unit
    task automatic test_first_windows();
        send_sample(1'b1, '0, '1, '0);
        send_sample(1'b0, '1, '1, '1);
        for (int k = 1; k < tmto_pkg::WINDOW; k++)
            send_sample(1'b1, '1, 32'(k), 32'hFFFF_FFFF - 32'(k * 1000));
        send_sample(1'b1, '1, '0, '0);
        send_sample(1'b0, '0, '0, '0);
        for (int k = 1; k < tmto_pkg::WINDOW; k++)
            send_sample(1'b1, 32'(k * 10), 32'hFFFF_FFFF - 32'(k), 32'(k));
        send_sample(1'b1, '0, '1, '0);
    endtask

    task automatic run_divisor_phase(input logic [tmto_pkg::STAMP_W-1:0] divisor,
                                     input logic [tmto_pkg::STAMP_W-1:0] base);
        logic [tmto_pkg::STAMP_W-1:0] g, n, l;
        write_unit_divisor(divisor);
        track_base = base;
        repeat (PHASE_ITEMS) begin
            pick_stamps(g, n, l);
            send_sample($urandom_range(0, 9) != 0, g, n, l);
        end
    endtask

    task automatic test_divisor_sweep();
        run_divisor_phase(32'd1, $urandom);
        run_divisor_phase('0, $urandom);
        run_divisor_phase('1, $urandom);
        // unit of one for high GPS means: offsets span the whole range
        run_divisor_phase(32'h8000_0000, 32'hC000_0000);
        run_divisor_phase(32'd7, $urandom);
        run_divisor_phase($urandom_range(32'hFFFF_FFFF, 1), $urandom);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_divisor_phase(tmto_pkg::UNIT_RESET, $urandom);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_hold_off();
        logic [tmto_pkg::STAMP_W-1:0] g, n, l;
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) begin
            pick_stamps(g, n, l);
            send_sample(1'b1, g, n, l);
        end
    endtask

    initial begin : rx_side
        int len;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                len = pick_gap();
                if (len == 0) len = 1;
                i_out_stall <= 1'b1;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_offset_report want;
        if (i_rst_n && i_in_valid && o_in_stall) in_stalled++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("Unexpected result %0d: gps_mean %h nr_mean %h lte_mean %h",
                             results_seen, o_gps_mean, o_nr_mean, o_lte_mean);
            end else begin
                want = expected_reports.pop_front();
                if (want.zero_unit) zero_unit_seen++;
                flag_field("gps_mean", want.gps_mean, o_gps_mean);
                flag_field("nr_mean", want.nr_mean, o_nr_mean);
                flag_field("lte_mean", want.lte_mean, o_lte_mean);
                flag_field("nr_offset", want.nr_offset, $unsigned(o_nr_offset));
                flag_field("lte_offset", want.lte_offset, $unsigned(o_lte_offset));
                flag_field("zero_unit", want.zero_unit, o_zero_unit);
            end
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycles, expected_reports.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : main_seq
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_sample_valid = 1'b0;
        i_gps_stamp    = '0;
        i_nr_stamp     = '0;
        i_lte_stamp    = '0;
        foreach (stamp_ring[c, k]) stamp_ring[c][k] = '0;
        next_slot  = 0;
        have_first = 1'b0;
        unit_div   = tmto_pkg::UNIT_RESET;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_windows();
        test_divisor_sweep();
        test_output_hold_off();

        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions and %0d results (%0d with a zero scale unit)",
                 samples_sent, results_seen, zero_unit_seen);
        $display("over %0d divisor writes; input held off for %0d cycles, %0d mismatches",
                 settings_used, in_stalled, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
